FILE: design/symmetric_fir_16tap_complex_assert.svh
// Assertion macros shared by the filter's modules.
`ifndef SYMMETRIC_FIR_16TAP_COMPLEX_ASSERT_SVH
`define SYMMETRIC_FIR_16TAP_COMPLEX_ASSERT_SVH

`ifndef SYNTH
`define SFIR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SFIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SFIR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SFIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/sfir_pkg.sv
package sfir_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int COEF_W            = 16;
   localparam int PRE_W             = SAMPLE_W + 1;
   localparam int PROD_W            = PRE_W + COEF_W;
   localparam int NUM_PAIRS         = 8;
   localparam int ACC_W             = PROD_W + 3;
   localparam int DELAY_DEPTH       = 2 * NUM_PAIRS - 1;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = COEF_W;
   localparam int OUT_SHIFT_DEFAULT = 15;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_PAIRS] = '{
      -16'sd1000, 16'sd2000, -16'sd3000, 16'sd4000,
      -16'sd5000, 16'sd6000, -16'sd7000, 16'sd8000
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_im;
      logic signed [SAMPLE_W-1:0] sample_re;
   } sample_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_im;
      logic signed [SAMPLE_W-1:0] out_re;
   } result_type;

   typedef struct packed {
      logic [NUM_PAIRS-1:0][PRE_W-1:0] pre_im;
      logic [NUM_PAIRS-1:0][PRE_W-1:0] pre_re;
   } preadd_type;

endpackage

FILE: design/symmetric_fir_16tap_complex.sv
// Sixteen-tap symmetric FIR on complex samples with eight programmable real
// coefficients. One sample beat is accepted per clock while the queue has room
// and one result beat is delivered per sample, so the sustained rate is one beat
// per cycle while the output side is ready, set by the fully pipelined multiply
// and add path with one multiplier per tap pair and channel. A result passes
// through the queue behind the delay line and pre-adders, then one register each
// for products, partial sums, the rounded and shifted sum, and the saturated
// output. The queue holds QueueDepth beats so the input keeps flowing briefly
// while the output stalls. Coefficients should only be written while no
// samples are in flight.
module symmetric_fir_16tap_complex import sfir_pkg::*; #(
   parameter int OutShift   = OUT_SHIFT_DEFAULT,
   parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sample_type            req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output result_type            rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       push_valid, push_ready;
   preadd_type push_data;
   logic       pop_valid, pop_ready;
   preadd_type pop_data;

   sfir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sfir_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sfir_back #(
      .OutShift (OutShift)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/sfir_front.sv
module sfir_front import sfir_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_data,
   output logic       push_valid,
   input  logic       push_ready,
   output preadd_type push_data
);

   sample_type delay_line_ff [DELAY_DEPTH];
   sample_type delay_line_in [DELAY_DEPTH];
   logic       accept;

   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign accept     = req_valid & push_ready;

   always_comb begin
      push_data.pre_re[0] = PRE_W'(req_data.sample_re)
                          + PRE_W'(delay_line_ff[DELAY_DEPTH-1].sample_re);
      push_data.pre_im[0] = PRE_W'(req_data.sample_im)
                          + PRE_W'(delay_line_ff[DELAY_DEPTH-1].sample_im);
      for (int k = 1; k < NUM_PAIRS; k++) begin
         push_data.pre_re[k] = PRE_W'(delay_line_ff[k-1].sample_re)
                             + PRE_W'(delay_line_ff[DELAY_DEPTH-1-k].sample_re);
         push_data.pre_im[k] = PRE_W'(delay_line_ff[k-1].sample_im)
                             + PRE_W'(delay_line_ff[DELAY_DEPTH-1-k].sample_im);
      end
   end

   always_comb begin
      delay_line_in[0] = req_data;
      for (int i = 1; i < DELAY_DEPTH; i++) begin
         delay_line_in[i] = delay_line_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            delay_line_ff[i] <= '0;
         end
      end else if (accept) begin
         delay_line_ff <= delay_line_in;
      end
   end

endmodule

FILE: design/sfir_queue.sv
`include "symmetric_fir_16tap_complex_assert.svh"

module sfir_queue import sfir_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  preadd_type push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output preadd_type pop_data
);

   localparam int PTR_W = $clog2(Depth);
   localparam int CNT_W = $clog2(Depth + 1);

   preadd_type       entry_ff [Depth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SFIR_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(Depth))
   `SFIR_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: design/sfir_back.sv
`include "symmetric_fir_16tap_complex_assert.svh"

module sfir_back import sfir_pkg::*; #(
   parameter int OutShift = OUT_SHIFT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  preadd_type            pop_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output result_type            rsp_data
);

   localparam int HALF    = NUM_PAIRS / 2;
   localparam int PSUM_W  = PROD_W + $clog2(HALF);
   localparam int SUM_W   = ((ACC_W > OutShift + 1) ? ACC_W : OutShift + 1) + 1;
   localparam int RND_POS = (OutShift > 0) ? OutShift - 1 : 0;
   localparam logic signed [SUM_W-1:0] RND =
      (OutShift > 0) ? ({{(SUM_W-1){1'b0}}, 1'b1} << RND_POS) : '0;

   logic signed [COEF_W-1:0] coef_ff [NUM_PAIRS];

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic signed [PROD_W-1:0] prod_re_ff [NUM_PAIRS];
   logic signed [PROD_W-1:0] prod_im_ff [NUM_PAIRS];
   logic signed [PROD_W-1:0] prod_re_in [NUM_PAIRS];
   logic signed [PROD_W-1:0] prod_im_in [NUM_PAIRS];
   logic signed [PSUM_W-1:0] psum_re_ff [2];
   logic signed [PSUM_W-1:0] psum_im_ff [2];
   logic signed [PSUM_W-1:0] psum_re_in [2];
   logic signed [PSUM_W-1:0] psum_im_in [2];
   logic signed [SUM_W-1:0]  scaled_re_ff, scaled_re_in;
   logic signed [SUM_W-1:0]  scaled_im_ff, scaled_im_in;
   logic signed [ACC_W-1:0]  acc_re, acc_im;
   result_type               rsp_data_ff, rsp_data_in;
   logic                     advance;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] max_v;
      logic signed [SUM_W-1:0] min_v;
      max_v = SUM_W'(32767);
      min_v = -max_v - SUM_W'(1);
      if (v > max_v) begin
         return SAMPLE_W'(max_v);
      end else if (v < min_v) begin
         return SAMPLE_W'(min_v);
      end
      return SAMPLE_W'(v);
   endfunction

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_PAIRS; k++) begin
            coef_ff[k] <= COEF_RESET[k];
         end
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
         prod_re_in[k] = $signed(pop_data.pre_re[k]) * coef_ff[k];
         prod_im_in[k] = $signed(pop_data.pre_im[k]) * coef_ff[k];
      end
   end

   always_comb begin
      for (int h = 0; h < 2; h++) begin
         psum_re_in[h] = '0;
         psum_im_in[h] = '0;
         for (int j = 0; j < HALF; j++) begin
            psum_re_in[h] = psum_re_in[h] + PSUM_W'(prod_re_ff[h*HALF+j]);
            psum_im_in[h] = psum_im_in[h] + PSUM_W'(prod_im_ff[h*HALF+j]);
         end
      end
   end

   always_comb begin
      acc_re       = ACC_W'(psum_re_ff[0]) + ACC_W'(psum_re_ff[1]);
      acc_im       = ACC_W'(psum_im_ff[0]) + ACC_W'(psum_im_ff[1]);
      scaled_re_in = (SUM_W'(acc_re) + RND) >>> OutShift;
      scaled_im_in = (SUM_W'(acc_im) + RND) >>> OutShift;
      rsp_data_in.out_re = sat16(scaled_re_ff);
      rsp_data_in.out_im = sat16(scaled_im_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_re_ff   <= prod_re_in;
         prod_im_ff   <= prod_im_in;
         psum_re_ff   <= psum_re_in;
         psum_im_ff   <= psum_im_in;
         scaled_re_ff <= scaled_re_in;
         scaled_im_ff <= scaled_im_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   `SFIR_ASSERT_NEXT(a_hold_on_stall, clock, reset, !advance, $stable(rsp_data_ff))
   `SFIR_ASSERT_NEXT(a_last_stage_out, clock, reset, s3_valid_ff && advance, rsp_valid_ff)

endmodule
